/* design/dfc_pkg.sv */
`timescale 1ns / 1ps

package dfc_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int POS_W        = $clog2(BUFFER_DEPTH);
	localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);

	// operation codes
	localparam logic [1:0] OP_RECEIVE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	// frame modes
	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_DOLLAR = 3'd1;
	localparam logic [2:0] MODE_HASH   = 3'd2;
	localparam logic [2:0] MODE_BRACE  = 3'd3;
	localparam logic [2:0] MODE_ANGLE  = 3'd4;
	localparam logic [2:0] MODE_AT     = 3'd5;

	// delimiter characters
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_LANGLE  = 8'h3C;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_RANGLE  = 8'h3E;

	typedef struct packed {
		logic       frame_ready;
		logic [2:0] frame_mode;
		logic [6:0] frame_length;
		logic       byte_dropped;
		logic [7:0] read_data;
	} result_t;

	function automatic logic [2:0] mode_of_start(input logic [7:0] b, input logic [2:0] mode);
		logic [2:0] m;
		begin
			case (b)
				CH_DOLLAR: m = MODE_DOLLAR;
				CH_HASH:   m = MODE_HASH;
				CH_LBRACE: m = MODE_BRACE;
				CH_LANGLE: m = MODE_ANGLE;
				CH_AT:     m = MODE_AT;
				default:   m = mode;
			endcase
			return m;
		end
	endfunction

	function automatic logic ends_frame(input logic [2:0] mode, input logic [7:0] b);
		logic e;
		begin
			case (mode)
				MODE_DOLLAR, MODE_HASH, MODE_AT: e = (b == CH_BANG);
				MODE_BRACE:                      e = (b == CH_RBRACE);
				MODE_ANGLE:                      e = (b == CH_RANGLE);
				default:                         e = 1'b0;
			endcase
			return e;
		end
	endfunction

endpackage

/* design/dfc_core.sv */
`timescale 1ns / 1ps

module dfc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [1:0]       operation,
	input  logic [7:0]       rx_byte,
	input  logic [5:0]       read_index,
	output logic             valid_s1,
	output dfc_pkg::result_t result_s1
);

	logic [dfc_pkg::POS_W-1:0] write_pos_q;
	logic [2:0]                mode_q;
	logic                      pending_q;
	logic [dfc_pkg::LEN_W-1:0] length_q;

	logic [7:0] frame_store [dfc_pkg::BUFFER_DEPTH];

	logic                      is_rx, is_rel, is_rd, store_en, rd_in_range;
	logic [2:0]                mode_start, mode_n;
	logic                      pending_n;
	logic [dfc_pkg::LEN_W-1:0] pos_inc, length_n;
	logic [dfc_pkg::POS_W-1:0] write_pos_n, rd_addr;

	logic [2:0]                mode_s1;
	logic                      ready_s1, dropped_s1, rd_sel_s1;
	logic [6:0]                length_s1;
	logic [7:0]                rd_data_s1;

	always_comb begin
		is_rx       = (operation == dfc_pkg::OP_RECEIVE);
		is_rel      = (operation == dfc_pkg::OP_RELEASE);
		is_rd       = (operation == dfc_pkg::OP_READ);
		store_en    = is_rx && !pending_q;
		mode_start  = dfc_pkg::mode_of_start(rx_byte, mode_q);
		pos_inc     = dfc_pkg::LEN_W'(write_pos_q) + dfc_pkg::LEN_W'(1);
		rd_addr     = dfc_pkg::POS_W'(read_index);
		rd_in_range = (32'(read_index) < dfc_pkg::BUFFER_DEPTH);

		mode_n      = mode_q;
		pending_n   = pending_q;
		length_n    = length_q;
		write_pos_n = write_pos_q;
		if (store_en) begin
			mode_n = mode_start;
			// wrap after the length is taken: a frame in the last slot reports full depth
			if (pos_inc == dfc_pkg::LEN_W'(dfc_pkg::BUFFER_DEPTH)) begin
				write_pos_n = '0;
			end else begin
				write_pos_n = dfc_pkg::POS_W'(pos_inc);
			end
			if (dfc_pkg::ends_frame(mode_start, rx_byte)) begin
				pending_n = 1'b1;
				length_n  = pos_inc;
			end
		end else if (is_rel) begin
			pending_n   = 1'b0;
			write_pos_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			mode_q      <= dfc_pkg::MODE_NONE;
			pending_q   <= 1'b0;
			length_q    <= '0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				write_pos_q <= write_pos_n;
				mode_q      <= mode_n;
				pending_q   <= pending_n;
				length_q    <= length_n;
			end
		end
	end

	// result fields of the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			ready_s1   <= pending_n;
			mode_s1    <= mode_n;
			length_s1  <= pending_n ? 7'(length_n) : 7'd0;
			dropped_s1 <= is_rx && pending_q;
			rd_sel_s1  <= is_rd && rd_in_range;
		end
	end

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && store_en) begin
			frame_store[write_pos_q] <= rx_byte;
		end
		if (accept && is_rd) begin
			rd_data_s1 <= frame_store[rd_addr];
		end
	end

	always_comb begin
		result_s1.frame_ready  = ready_s1;
		result_s1.frame_mode   = mode_s1;
		result_s1.frame_length = length_s1;
		result_s1.byte_dropped = dropped_s1;
		result_s1.read_data    = rd_sel_s1 ? rd_data_s1 : 8'd0;
	end

endmodule

/* design/dfc_out_queue.sv */
`timescale 1ns / 1ps

module dfc_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dfc_pkg::result_t push_data,
	input  logic             stall,
	output logic             valid,
	output dfc_pkg::result_t data,
	output logic [1:0]       level
);

	logic             head_v_q, skid_v_q;
	dfc_pkg::result_t head_q, skid_q;
	logic             pop;

	assign pop   = head_v_q && !stall;
	assign valid = head_v_q;
	assign data  = head_q;
	assign level = 2'(head_v_q) + 2'(skid_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop || !head_v_q) begin
				head_v_q <= skid_v_q || push;
				skid_v_q <= skid_v_q && push;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !head_v_q) begin
			head_q <= skid_v_q ? skid_q : push_data;
			if (skid_v_q && push) begin
				skid_q <= push_data;
			end
		end else if (push && !skid_v_q) begin
			skid_q <= push_data;
		end
	end

endmodule

/* design/delimited_frame_collector.sv */
`timescale 1ns / 1ps

// Delimited frame collector.
// Item channel (item_valid / item_stall): one transfer carries an operation:
// receive a byte, release the completed frame, or read one buffer entry.
// Result channel (result_valid / result_stall): exactly one result transfer per
// item, in order: ready flag, current mode, captured length, drop flag and
// read data.
// Throughput: one item per cycle while item_stall is low. Each item touches
// the frame store at most once (one write or one read) and updates a handful
// of registers. A result is offered after its item passes the read stage,
// which holds the registered read of the frame store, and the output register.
// Stalling: a two-entry output queue (output register plus skid) holds
// results while the receiver stalls. item_stall rises when three results are
// held in the read stage and queue, or two are and the head is not leaving.
// Reset: arst_n clears mode, ready flag, length and write position at once.
// The frame store is not cleared; entries read before being written return
// undefined data.
module delimited_frame_collector (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] operation,
	input  logic [7:0] rx_byte,
	input  logic [5:0] read_index,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       frame_ready,
	output logic [2:0] frame_mode,
	output logic [6:0] frame_length,
	output logic       byte_dropped,
	output logic [7:0] read_data
);

	logic             accept;
	logic             valid_s1;
	dfc_pkg::result_t result_s1;
	dfc_pkg::result_t out_data;
	logic [1:0]       level;
	logic [1:0]       in_flight;
	logic             head_leaves;

	// results in flight downstream of the input: read stage plus queue
	assign in_flight   = level + 2'(valid_s1);
	assign head_leaves = result_valid && !result_stall;
	assign item_stall  = !((in_flight < 2'd2) || ((in_flight == 2'd2) && head_leaves));
	assign accept      = item_valid && !item_stall;

	dfc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.read_index (read_index),
		.valid_s1   (valid_s1),
		.result_s1  (result_s1)
	);

	dfc_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (result_s1),
		.stall     (result_stall),
		.valid     (result_valid),
		.data      (out_data),
		.level     (level)
	);

	assign frame_ready  = out_data.frame_ready;
	assign frame_mode   = out_data.frame_mode;
	assign frame_length = out_data.frame_length;
	assign byte_dropped = out_data.byte_dropped;
	assign read_data    = out_data.read_data;

endmodule
